@@ hw/rtl/bspm_pkg.sv @@
// ----------------------------------------------------------------------------
// bspm_pkg
// Types and constants shared by the battery and sleep power manager modules.
// ----------------------------------------------------------------------------
package bspm_pkg;

  // Item kinds on the input channel
  localparam logic [1:0] KIND_TICK     = 2'd0;
  localparam logic [1:0] KIND_ACTIVITY = 2'd1;
  localparam logic [1:0] KIND_CLEAR    = 2'd2;

  // Requested brightness modes
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_LOW    = 2'd1;
  localparam logic [1:0] MODE_SLEEP  = 2'd2;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_CHECK_INTERVAL = 3'd0;
  localparam logic [2:0] REG_LOW_THRESHOLD  = 3'd1;
  localparam logic [2:0] REG_RECOVER_MARGIN = 3'd2;
  localparam logic [2:0] REG_FULL_CODE      = 3'd3;
  localparam logic [2:0] REG_ACT_TIMEOUT    = 3'd4;
  localparam logic [2:0] REG_FADE_DURATION  = 3'd5;
  localparam logic [2:0] REG_PWR_SAVE_EN    = 3'd6;

  // Field widths
  localparam int CODE_W  = 10;
  localparam int PCT_W   = 7;
  localparam int NUM_W   = 17;  // (code - low) * 100 fits in 17 bits
  localparam int CFG_W   = 32;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  // Reset values of the registers
  localparam logic [15:0]       RST_CHECK_INTERVAL = 16'd1000;
  localparam logic [CODE_W-1:0] RST_LOW_THRESHOLD  = 10'd600;
  localparam logic [CODE_W-1:0] RST_RECOVER_MARGIN = 10'd40;
  localparam logic [CODE_W-1:0] RST_FULL_CODE      = 10'd800;
  localparam logic [31:0]       RST_ACT_TIMEOUT    = 32'd300000;
  localparam logic [15:0]       RST_FADE_DURATION  = 16'd2000;

  typedef struct packed {
    logic [15:0]       check_interval_ms;
    logic [CODE_W-1:0] low_threshold_code;
    logic [CODE_W-1:0] recover_margin_code;
    logic [CODE_W-1:0] full_code;
    logic [31:0]       activity_timeout_ms;
    logic [15:0]       fade_duration_ms;
    logic              power_saving_enable;
  } bspm_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_PCT,
    ST_DIV,
    ST_DONE
  } bspm_state_t;

endpackage

@@ hw/rtl/bspm_cfg.sv @@
// ----------------------------------------------------------------------------
// bspm_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module bspm_cfg
  import bspm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  output bspm_cfg_t        cfg
);

  bspm_cfg_t cfg_r;
  bspm_cfg_t cfg_nxt;

  // Decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_CHECK_INTERVAL: cfg_nxt.check_interval_ms   = cfg_wdata[15:0];
        REG_LOW_THRESHOLD:  cfg_nxt.low_threshold_code  = cfg_wdata[CODE_W-1:0];
        REG_RECOVER_MARGIN: cfg_nxt.recover_margin_code = cfg_wdata[CODE_W-1:0];
        REG_FULL_CODE:      cfg_nxt.full_code           = cfg_wdata[CODE_W-1:0];
        REG_ACT_TIMEOUT:    cfg_nxt.activity_timeout_ms = cfg_wdata;
        REG_FADE_DURATION:  cfg_nxt.fade_duration_ms    = cfg_wdata[15:0];
        REG_PWR_SAVE_EN:    cfg_nxt.power_saving_enable = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.check_interval_ms   <= RST_CHECK_INTERVAL;
      cfg_r.low_threshold_code  <= RST_LOW_THRESHOLD;
      cfg_r.recover_margin_code <= RST_RECOVER_MARGIN;
      cfg_r.full_code           <= RST_FULL_CODE;
      cfg_r.activity_timeout_ms <= RST_ACT_TIMEOUT;
      cfg_r.fade_duration_ms    <= RST_FADE_DURATION;
      cfg_r.power_saving_enable <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hw/rtl/bspm_div.sv @@
// ----------------------------------------------------------------------------
// bspm_div
// Iterative restoring divider for the charge percent, one quotient bit a
// cycle. The caller guarantees the quotient fits in PCT_W bits.
// ----------------------------------------------------------------------------
module bspm_div
  import bspm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [CODE_W-1:0] den,
  output logic              done,
  output logic [PCT_W-1:0]  quot
);

  localparam int STEP_W = $clog2(PCT_W);

  logic [NUM_W-1:0]  rem_r,  rem_nxt;
  logic [NUM_W-1:0]  dsh_r,  dsh_nxt;
  logic [PCT_W-1:0]  quot_r, quot_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              fits;

  // Trial subtraction of the shifted divisor
  assign fits = (rem_r >= dsh_r);

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quot_nxt = quot_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num;
      dsh_nxt  = NUM_W'(den) << (PCT_W - 1);
      quot_nxt = '0;
      step_nxt = STEP_W'(PCT_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = rem_r - dsh_r;
      end
      quot_nxt = {quot_r[PCT_W-2:0], fits};
      dsh_nxt  = dsh_r >> 1;
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    quot_r <= quot_nxt;
    step_r <= step_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

@@ hw/rtl/battery_and_sleep_power_manager.sv @@
// ----------------------------------------------------------------------------
// battery_and_sleep_power_manager
// Battery monitor with low-battery hysteresis and an idle fade-to-sleep
// sequencer, driven by millisecond tick items.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid / in_stall): one item per tick, activity event or
//  clear request; in_adc_sample is used on ticks that sample the battery.
//  Result channel (out_valid / out_stall): exactly one result item per input
//  item, showing the state after that item.
//  Configuration: cfg_we / cfg_index / cfg_wdata, written while idle.
//  Sequence: an accepted item passes through UPDATE and PCT, then DIV when
//  the percent needs the seven-step division in the divider, and DONE; it
//  skips DIV when the percent clamps to 0 or 100. One item is worked on at a
//  time, so the next item is taken only once the block is back in IDLE.
//  in_stall is high from acceptance until the result is loaded into the
//  output register; a result waiting there does not block the next item.
//  If the receiver stalls and the output register is still full when the
//  next result is ready, the block holds that result and keeps in_stall high.
//  Reset (rst_n low, synchronous) loads default configuration, clears the
//  activity and fade counters and the flags, and arms the check counter so the first tick samples.
// ----------------------------------------------------------------------------
module battery_and_sleep_power_manager
  import bspm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_kind,
  input  logic [CODE_W-1:0] in_adc_sample,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CODE_W-1:0] out_battery_code,
  output logic [PCT_W-1:0]  out_battery_percent,
  output logic              out_low_battery,
  output logic              out_change_requested,
  output logic [1:0]        out_requested_mode,
  output logic              out_preparing_sleep,
  output logic              out_deep_sleep
);

  bspm_cfg_t cfg;

  bspm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Sequencer and state
  bspm_state_t       state_r, state_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic [CODE_W-1:0] adc_r, adc_nxt;
  logic [15:0]       since_check_r, since_check_nxt;
  logic [31:0]       since_active_r, since_active_nxt;
  logic [15:0]       since_fade_r, since_fade_nxt;
  logic [CODE_W-1:0] last_code_r, last_code_nxt;
  logic              low_mode_r, low_mode_nxt;
  logic              pending_r, pending_nxt;
  logic [1:0]        mode_r, mode_nxt;
  logic              fading_r, fading_nxt;
  logic              asleep_r, asleep_nxt;
  logic [PCT_W-1:0]  pct_r, pct_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0] o_code_r, o_code_nxt;
  logic [PCT_W-1:0]  o_pct_r, o_pct_nxt;
  logic              o_low_r, o_low_nxt;
  logic              o_pend_r, o_pend_nxt;
  logic [1:0]        o_mode_r, o_mode_nxt;
  logic              o_fade_r, o_fade_nxt;
  logic              o_sleep_r, o_sleep_nxt;

  // Divider
  logic              div_start;
  logic              div_done;
  logic [PCT_W-1:0]  div_quot;
  logic [CODE_W-1:0] code_diff;
  logic [CODE_W-1:0] span;
  logic [NUM_W-1:0]  div_num;

  // Tick arithmetic
  logic [15:0]       sc_inc;
  logic [31:0]       sa_inc;
  logic [15:0]       sf_inc;
  logic              do_sample;
  logic [CODE_W:0]   recover_level;

  assign sc_inc = (since_check_r == 16'hFFFF) ? since_check_r : since_check_r + 16'd1;
  assign sa_inc = (since_active_r == 32'hFFFF_FFFF) ? since_active_r
                                                    : since_active_r + 32'd1;
  assign sf_inc = !fading_r ? since_fade_r :
                  (since_fade_r == 16'hFFFF) ? since_fade_r : since_fade_r + 16'd1;
  assign do_sample     = (sc_inc >= cfg.check_interval_ms);
  assign recover_level = {1'b0, cfg.low_threshold_code} + {1'b0, cfg.recover_margin_code};

  assign code_diff = last_code_r - cfg.low_threshold_code;
  assign span      = cfg.full_code - cfg.low_threshold_code;
  assign div_num   = NUM_W'(code_diff) * NUM_W'(100);

  bspm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (span),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Next state and datapath control
  always_comb begin
    state_nxt        = state_r;
    kind_nxt         = kind_r;
    adc_nxt          = adc_r;
    since_check_nxt  = since_check_r;
    since_active_nxt = since_active_r;
    since_fade_nxt   = since_fade_r;
    last_code_nxt    = last_code_r;
    low_mode_nxt     = low_mode_r;
    pending_nxt      = pending_r;
    mode_nxt         = mode_r;
    fading_nxt       = fading_r;
    asleep_nxt       = asleep_r;
    pct_nxt          = pct_r;
    div_start        = 1'b0;

    out_valid_nxt = out_valid_r & out_stall;
    o_code_nxt    = o_code_r;
    o_pct_nxt     = o_pct_r;
    o_low_nxt     = o_low_r;
    o_pend_nxt    = o_pend_r;
    o_mode_nxt    = o_mode_r;
    o_fade_nxt    = o_fade_r;
    o_sleep_nxt   = o_sleep_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_kind;
          adc_nxt   = in_adc_sample;
          state_nxt = ST_UPDATE;
        end
      end

      ST_UPDATE: begin
        case (kind_r)
          KIND_TICK: begin
            since_check_nxt  = sc_inc;
            since_active_nxt = sa_inc;
            since_fade_nxt   = sf_inc;
            // battery sample with hysteresis
            if (do_sample) begin
              last_code_nxt   = adc_r;
              since_check_nxt = '0;
              if ((adc_r < cfg.low_threshold_code) && !low_mode_r) begin
                low_mode_nxt = 1'b1;
                mode_nxt     = MODE_LOW;
                pending_nxt  = 1'b1;
              end else if (({1'b0, adc_r} > recover_level) && low_mode_r) begin
                low_mode_nxt = 1'b0;
                mode_nxt     = MODE_NORMAL;
                pending_nxt  = 1'b1;
              end
            end
            // idle timeout starts the fade once
            if (cfg.power_saving_enable && (sa_inc > cfg.activity_timeout_ms) && !fading_r) begin
              mode_nxt       = MODE_SLEEP;
              pending_nxt    = 1'b1;
              fading_nxt     = 1'b1;
              since_fade_nxt = '0;
              if (cfg.fade_duration_ms == '0) begin
                asleep_nxt = 1'b1;
              end
            end else if (fading_r && (sf_inc >= cfg.fade_duration_ms)) begin
              asleep_nxt = 1'b1;
            end
          end
          KIND_ACTIVITY: since_active_nxt = '0;
          KIND_CLEAR:    pending_nxt      = 1'b0;
          default: ;
        endcase
        state_nxt = ST_PCT;
      end

      // Percent: clamp ends directly, divide otherwise
      ST_PCT: begin
        if (last_code_r <= cfg.low_threshold_code) begin
          pct_nxt   = '0;
          state_nxt = ST_DONE;
        end else if (last_code_r >= cfg.full_code) begin
          pct_nxt   = PCT_FULL;
          state_nxt = ST_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end

      ST_DIV: begin
        if (div_done) begin
          pct_nxt   = div_quot;
          state_nxt = ST_DONE;
        end
      end

      // Load the output register once it is free
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          o_code_nxt    = last_code_r;
          o_pct_nxt     = pct_r;
          o_low_nxt     = low_mode_r;
          o_pend_nxt    = pending_r;
          o_mode_nxt    = mode_r;
          o_fade_nxt    = fading_r;
          o_sleep_nxt   = asleep_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      since_check_r  <= 16'hFFFF;
      since_active_r <= '0;
      since_fade_r   <= '0;
      last_code_r    <= '0;
      low_mode_r     <= 1'b0;
      pending_r      <= 1'b0;
      mode_r         <= MODE_NORMAL;
      fading_r       <= 1'b0;
      asleep_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      since_check_r  <= since_check_nxt;
      since_active_r <= since_active_nxt;
      since_fade_r   <= since_fade_nxt;
      last_code_r    <= last_code_nxt;
      low_mode_r     <= low_mode_nxt;
      pending_r      <= pending_nxt;
      mode_r         <= mode_nxt;
      fading_r       <= fading_nxt;
      asleep_r       <= asleep_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    adc_r     <= adc_nxt;
    pct_r     <= pct_nxt;
    o_code_r  <= o_code_nxt;
    o_pct_r   <= o_pct_nxt;
    o_low_r   <= o_low_nxt;
    o_pend_r  <= o_pend_nxt;
    o_mode_r  <= o_mode_nxt;
    o_fade_r  <= o_fade_nxt;
    o_sleep_r <= o_sleep_nxt;
  end

  assign in_stall             = (state_r != ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_battery_code     = o_code_r;
  assign out_battery_percent  = o_pct_r;
  assign out_low_battery      = o_low_r;
  assign out_change_requested = o_pend_r;
  assign out_requested_mode   = o_mode_r;
  assign out_preparing_sleep  = o_fade_r;
  assign out_deep_sleep       = o_sleep_r;

endmodule
